// File: design/euler_to_rotation_matrix_assert.svh
// assertion macros shared by the rotation matrix design
`ifndef EULER_TO_ROTATION_MATRIX_ASSERT_SVH
`define EULER_TO_ROTATION_MATRIX_ASSERT_SVH
`ifndef SYNTHESIS
`define EULR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define EULR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define EULR_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define EULR_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// File: design/eulr_pkg.sv
// constants, types and rounding helper for the euler angle rotation matrix
`timescale 1ns / 1ps
package eulr_pkg;
   localparam int ANGLE_BITS   = 16;
   localparam int ELEMENT_BITS = 16;
   localparam int QF           = 30;
   localparam int ASH          = 33 - ANGLE_BITS;
   localparam int ESH          = QF - (ELEMENT_BITS - 2);

   localparam int IN_W  = ((3 * ANGLE_BITS + 7) / 8) * 8;
   localparam int OUT_W = ((9 * ELEMENT_BITS + 7) / 8) * 8;

   localparam logic signed [33:0] Q_PI      = 34'sd3373259426;
   localparam logic signed [33:0] Q_HALF_PI = 34'sd1686629713;
   localparam logic signed [33:0] Q_TWO_PI  = 34'sd6746518852;
   localparam logic signed [31:0] Q_ONE     = 32'sh4000_0000;
   localparam logic signed [33:0] E_ONE     = 34'sd1 <<< (ELEMENT_BITS - 2);

   localparam int SIN_N       = 6;
   localparam int COS_N       = 7;
   localparam int ITER_STAGES = 4;
   localparam int A_DLY       = 2 + SIN_N * ITER_STAGES;
   localparam int C_DLY       = 2 + COS_N * ITER_STAGES;
   localparam int S_DLY       = (COS_N - SIN_N) * ITER_STAGES - 2;
   localparam int SC_LAT      = 5 + COS_N * ITER_STAGES;
   localparam int MAT_LAT     = 6;
   localparam int PIPE_LAT    = SC_LAT + MAT_LAT;

   localparam logic [7:0] SIN_DIV [SIN_N] = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
   localparam logic [7:0] COS_DIV [COS_N] =
      '{8'd182, 8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
   localparam logic [31:0] SIN_RCP [SIN_N] = '{
      32'((64'd1 << 32) / 64'd156), 32'((64'd1 << 32) / 64'd110),
      32'((64'd1 << 32) / 64'd72),  32'((64'd1 << 32) / 64'd42),
      32'((64'd1 << 32) / 64'd20),  32'((64'd1 << 32) / 64'd6)};
   localparam logic [31:0] COS_RCP [COS_N] = '{
      32'((64'd1 << 32) / 64'd182), 32'((64'd1 << 32) / 64'd132),
      32'((64'd1 << 32) / 64'd90),  32'((64'd1 << 32) / 64'd56),
      32'((64'd1 << 32) / 64'd30),  32'((64'd1 << 32) / 64'd12),
      32'((64'd1 << 32) / 64'd2)};

   typedef logic signed [31:0] q30_type;

   typedef struct packed {
      logic full;
      logic valid;
   } obuf_stat_type;

   // shift right rounding half away from zero
   function automatic logic signed [63:0] round_shr(input logic signed [63:0] v,
                                                    input int unsigned s);
      logic [63:0] mag;
      logic [63:0] half;
      logic [63:0] r;
      mag  = v[63] ? 64'(-v) : 64'(v);
      half = (s == 0) ? 64'd0 : (64'd1 << (s - 1));
      r    = (mag + half) >> s;
      return v[63] ? -$signed(r) : $signed(r);
   endfunction
endpackage

// File: design/eulr_iter.sv
// one series step t' = 1 - round(x2 * t) / k, four register stages
`timescale 1ns / 1ps
module eulr_iter (
   input  logic                clock,
   input  logic                en,
   input  logic [31:0]         x2_val,
   input  logic [30:0]         t_val,
   input  logic [7:0]          k_val,
   input  logic [31:0]         rcp_val,
   output logic [31:0]         x2_out,
   output logic signed [31:0]  t_out
);
   logic [62:0] p_ff;
   logic [31:0] x2a_ff, x2b_ff, x2c_ff, x2d_ff;
   logic [31:0] n_ff, n2_ff;
   logic [63:0] e_ff;
   logic signed [31:0] t_ff;
   logic [31:0] est;
   logic [39:0] ek;
   logic [31:0] rem;
   logic [31:0] quo;
   logic signed [31:0] t_in;

   // reciprocal estimate is low by at most one
   always_comb begin
      est  = e_ff[63:32];
      ek   = 40'(est) * 40'(k_val);
      rem  = n2_ff - ek[31:0];
      quo  = (rem >= 32'(k_val)) ? est + 32'd1 : est;
      t_in = eulr_pkg::Q_ONE - $signed(quo);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff   <= 63'(x2_val) * 63'(t_val);
         x2a_ff <= x2_val;
         n_ff   <= 32'((p_ff + (63'd1 << (eulr_pkg::QF - 1))) >> eulr_pkg::QF);
         x2b_ff <= x2a_ff;
         e_ff   <= 64'(n_ff) * 64'(rcp_val);
         n2_ff  <= n_ff;
         x2c_ff <= x2b_ff;
         t_ff   <= t_in;
         x2d_ff <= x2c_ff;
      end
   end

   assign x2_out = x2d_ff;
   assign t_out  = t_ff;
endmodule

// File: design/eulr_sincos.sv
// sine and cosine of one angle: range fold, square, series steps
`timescale 1ns / 1ps
module eulr_sincos (
   input  logic                             clock,
   input  logic                             en,
   input  logic [eulr_pkg::ANGLE_BITS-1:0]  angle,
   output eulr_pkg::q30_type                sin_val,
   output eulr_pkg::q30_type                cos_val
);
   logic signed [33:0] ext_w, wrap_in, wrap_ff, fold_w;
   logic signed [31:0] a_ff;
   logic               negc_in, negc_ff;
   logic signed [63:0] sq_ff;
   logic [31:0]        x2_ff;
   logic signed [31:0] a_dly_ff [eulr_pkg::A_DLY];
   logic               negc_dly_ff [eulr_pkg::C_DLY];
   logic signed [63:0] sm_ff;
   logic signed [31:0] sr_ff;
   logic signed [31:0] s_dly_ff [eulr_pkg::S_DLY];
   logic signed [31:0] s_out_ff, c_out_ff;

   logic [31:0]        cx2 [eulr_pkg::COS_N+1];
   logic signed [31:0] ct  [eulr_pkg::COS_N+1];
   logic [31:0]        sx2 [eulr_pkg::SIN_N+1];
   logic signed [31:0] st  [eulr_pkg::SIN_N+1];

   always_comb begin
      ext_w = $signed({{(34 - eulr_pkg::ANGLE_BITS){angle[eulr_pkg::ANGLE_BITS-1]}}, angle})
              <<< eulr_pkg::ASH;
      priority if (ext_w > eulr_pkg::Q_PI) begin
         wrap_in = ext_w - eulr_pkg::Q_TWO_PI;
      end else if (ext_w < -eulr_pkg::Q_PI) begin
         wrap_in = ext_w + eulr_pkg::Q_TWO_PI;
      end else begin
         wrap_in = ext_w;
      end
      // fold into +-pi/2, cosine changes sign
      priority if (wrap_ff > eulr_pkg::Q_HALF_PI) begin
         fold_w  = eulr_pkg::Q_PI - wrap_ff;
         negc_in = 1'b1;
      end else if (wrap_ff < -eulr_pkg::Q_HALF_PI) begin
         fold_w  = -eulr_pkg::Q_PI - wrap_ff;
         negc_in = 1'b1;
      end else begin
         fold_w  = wrap_ff;
         negc_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         wrap_ff  <= wrap_in;
         a_ff     <= fold_w[31:0];
         negc_ff  <= negc_in;
         sq_ff    <= 64'(a_ff) * 64'(a_ff);
         x2_ff    <= 32'(eulr_pkg::round_shr(sq_ff, eulr_pkg::QF));
         a_dly_ff[0]    <= a_ff;
         negc_dly_ff[0] <= negc_ff;
         for (int i = 1; i < eulr_pkg::A_DLY; i++) a_dly_ff[i] <= a_dly_ff[i-1];
         for (int i = 1; i < eulr_pkg::C_DLY; i++) negc_dly_ff[i] <= negc_dly_ff[i-1];
         sm_ff <= 64'(a_dly_ff[eulr_pkg::A_DLY-1]) *
                  64'($signed({1'b0, st[eulr_pkg::SIN_N][30:0]}));
         sr_ff <= 32'(eulr_pkg::round_shr(sm_ff, eulr_pkg::QF));
         s_dly_ff[0] <= sr_ff;
         for (int i = 1; i < eulr_pkg::S_DLY; i++) s_dly_ff[i] <= s_dly_ff[i-1];
         s_out_ff <= s_dly_ff[eulr_pkg::S_DLY-1];
         c_out_ff <= negc_dly_ff[eulr_pkg::C_DLY-1] ? -ct[eulr_pkg::COS_N]
                                                    : ct[eulr_pkg::COS_N];
      end
   end

   assign cx2[0] = x2_ff;
   assign ct[0]  = eulr_pkg::Q_ONE;
   assign sx2[0] = x2_ff;
   assign st[0]  = eulr_pkg::Q_ONE;

   for (genvar j = 0; j < eulr_pkg::COS_N; j++) begin : g_cos
      eulr_iter u_iter (
         .clock   (clock),
         .en      (en),
         .x2_val  (cx2[j]),
         .t_val   (ct[j][30:0]),
         .k_val   (eulr_pkg::COS_DIV[j]),
         .rcp_val (eulr_pkg::COS_RCP[j]),
         .x2_out  (cx2[j+1]),
         .t_out   (ct[j+1])
      );
   end

   for (genvar j = 0; j < eulr_pkg::SIN_N; j++) begin : g_sin
      eulr_iter u_iter (
         .clock   (clock),
         .en      (en),
         .x2_val  (sx2[j]),
         .t_val   (st[j][30:0]),
         .k_val   (eulr_pkg::SIN_DIV[j]),
         .rcp_val (eulr_pkg::SIN_RCP[j]),
         .x2_out  (sx2[j+1]),
         .t_out   (st[j+1])
      );
   end

   assign sin_val = s_out_ff;
   assign cos_val = c_out_ff;
endmodule

// File: design/eulr_matrix.sv
// products and sums of the sines and cosines, rounding and saturation
`timescale 1ns / 1ps
module eulr_matrix (
   input  logic                                    clock,
   input  logic                                    en,
   input  eulr_pkg::q30_type                       sr,
   input  eulr_pkg::q30_type                       cr,
   input  eulr_pkg::q30_type                       sp,
   input  eulr_pkg::q30_type                       cp,
   input  eulr_pkg::q30_type                       sy,
   input  eulr_pkg::q30_type                       cy,
   output logic [8:0][eulr_pkg::ELEMENT_BITS-1:0]  elem
);
   logic signed [31:0] ma [10];
   logic signed [31:0] mb [10];
   logic signed [63:0] p1_ff [10];
   logic signed [31:0] r1_ff [10];
   logic signed [31:0] h_ff  [10];
   logic signed [31:0] h2_ff [10];
   logic signed [63:0] p2_ff [4];
   logic signed [31:0] r2_ff [4];
   logic signed [31:0] sr_d1_ff, cr_d1_ff, sr_d2_ff, cr_d2_ff;
   logic signed [31:0] sp_d1_ff, sp_d2_ff, sp_d3_ff, sp_d4_ff;
   logic signed [33:0] e_in [9];
   logic signed [33:0] e_ff [9];
   logic signed [63:0] rnd_w [9];
   logic [8:0][eulr_pkg::ELEMENT_BITS-1:0] out_ff;

   // first products: cy*sp, sp*sy, then the plain pairs
   always_comb begin
      ma[0] = cy; mb[0] = sp;
      ma[1] = sp; mb[1] = sy;
      ma[2] = cy; mb[2] = cp;
      ma[3] = sy; mb[3] = cr;
      ma[4] = sy; mb[4] = sr;
      ma[5] = sy; mb[5] = cp;
      ma[6] = cy; mb[6] = cr;
      ma[7] = cy; mb[7] = sr;
      ma[8] = cp; mb[8] = sr;
      ma[9] = cp; mb[9] = cr;
   end

   always_comb begin
      e_in[0] = 34'(h2_ff[2]);
      e_in[1] = -34'(h2_ff[3]) + 34'(r2_ff[0]);
      e_in[2] = 34'(h2_ff[4]) + 34'(r2_ff[1]);
      e_in[3] = 34'(h2_ff[5]);
      e_in[4] = 34'(h2_ff[6]) + 34'(r2_ff[2]);
      e_in[5] = -34'(h2_ff[7]) + 34'(r2_ff[3]);
      e_in[6] = -34'(sp_d4_ff);
      e_in[7] = 34'(h2_ff[8]);
      e_in[8] = 34'(h2_ff[9]);
      for (int i = 0; i < 9; i++) begin
         rnd_w[i] = eulr_pkg::round_shr(64'(e_ff[i]), eulr_pkg::ESH);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 10; i++) begin
            p1_ff[i] <= 64'(ma[i]) * 64'(mb[i]);
            r1_ff[i] <= 32'(eulr_pkg::round_shr(p1_ff[i], eulr_pkg::QF));
            h_ff[i]  <= r1_ff[i];
            h2_ff[i] <= h_ff[i];
         end
         sr_d1_ff <= sr;
         cr_d1_ff <= cr;
         sr_d2_ff <= sr_d1_ff;
         cr_d2_ff <= cr_d1_ff;
         sp_d1_ff <= sp;
         sp_d2_ff <= sp_d1_ff;
         sp_d3_ff <= sp_d2_ff;
         sp_d4_ff <= sp_d3_ff;
         p2_ff[0] <= 64'(r1_ff[0]) * 64'(sr_d2_ff);
         p2_ff[1] <= 64'(r1_ff[0]) * 64'(cr_d2_ff);
         p2_ff[2] <= 64'(r1_ff[1]) * 64'(sr_d2_ff);
         p2_ff[3] <= 64'(r1_ff[1]) * 64'(cr_d2_ff);
         for (int i = 0; i < 4; i++) begin
            r2_ff[i] <= 32'(eulr_pkg::round_shr(p2_ff[i], eulr_pkg::QF));
         end
         for (int i = 0; i < 9; i++) begin
            e_ff[i] <= e_in[i];
            // saturate to plus or minus one
            if (rnd_w[i] > 64'(eulr_pkg::E_ONE)) begin
               out_ff[i] <= eulr_pkg::ELEMENT_BITS'(eulr_pkg::E_ONE);
            end else if (rnd_w[i] < -64'(eulr_pkg::E_ONE)) begin
               out_ff[i] <= eulr_pkg::ELEMENT_BITS'(-eulr_pkg::E_ONE);
            end else begin
               out_ff[i] <= eulr_pkg::ELEMENT_BITS'(rnd_w[i]);
            end
         end
      end
   end

   assign elem = out_ff;
endmodule

// File: design/eulr_obuf.sv
// two-entry output buffer between the pipeline and the result channel
`timescale 1ns / 1ps
module eulr_obuf (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  logic [eulr_pkg::OUT_W-1:0]  push_data,
   input  logic                        pop,
   output eulr_pkg::obuf_stat_type     stat,
   output logic [eulr_pkg::OUT_W-1:0]  head_data
);
   logic [eulr_pkg::OUT_W-1:0] ent_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       wr_ff, rd_ff;
   logic       do_pop;

   assign do_pop = pop && (cnt_ff != 2'd0);

   always_comb begin
      cnt_in = cnt_ff + 2'(push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wr_ff <= ~wr_ff;
         if (do_pop) rd_ff <= ~rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push) ent_ff[wr_ff] <= push_data;
   end

   assign stat.full  = (cnt_ff == 2'd2);
   assign stat.valid = (cnt_ff != 2'd0);
   assign head_data  = ent_ff[rd_ff];
endmodule

// File: design/euler_to_rotation_matrix.sv
// throughput: one angle triple per cycle while the output buffer is not full,
// set by the fully pipelined sine/cosine series
// the pipeline freezes only while the two-entry output buffer is full
// reset (synchronous, active high) clears the valid bits and the output buffer
// no state is kept between items
`timescale 1ns / 1ps
`include "euler_to_rotation_matrix_assert.svh"
module euler_to_rotation_matrix (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // roll_angle, pitch_angle, yaw_angle
   input  logic [eulr_pkg::IN_W-1:0]   req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // elem_r0_c0, r0_c1, r0_c2, r1_c0, r1_c1, r1_c2, r2_c0, r2_c1, r2_c2
   output logic [eulr_pkg::OUT_W-1:0]  rsp_tdata
);
   localparam int AB = eulr_pkg::ANGLE_BITS;

   logic en;
   logic [eulr_pkg::PIPE_LAT-1:0] vld_ff, vld_in;
   eulr_pkg::q30_type sr, cr, sp, cp, sy, cy;
   logic [8:0][eulr_pkg::ELEMENT_BITS-1:0] elem;
   eulr_pkg::obuf_stat_type ostat;
   logic push;

   assign en         = !ostat.full;
   assign req_tready = en;
   assign push       = en && vld_ff[eulr_pkg::PIPE_LAT-1];

   always_comb begin
      vld_in = {vld_ff[eulr_pkg::PIPE_LAT-2:0], req_tvalid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   eulr_sincos u_roll (
      .clock (clock), .en (en), .angle (req_tdata[AB-1:0]),
      .sin_val (sr), .cos_val (cr));
   eulr_sincos u_pitch (
      .clock (clock), .en (en), .angle (req_tdata[2*AB-1:AB]),
      .sin_val (sp), .cos_val (cp));
   eulr_sincos u_yaw (
      .clock (clock), .en (en), .angle (req_tdata[3*AB-1:2*AB]),
      .sin_val (sy), .cos_val (cy));

   eulr_matrix u_matrix (
      .clock (clock), .en (en),
      .sr (sr), .cr (cr), .sp (sp), .cp (cp), .sy (sy), .cy (cy),
      .elem (elem));

   eulr_obuf u_obuf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (eulr_pkg::OUT_W'(elem)),
      .pop       (rsp_tready),
      .stat      (ostat),
      .head_data (rsp_tdata));

   assign rsp_tvalid = ostat.valid;

   `EULR_ASSERT_NOW(a_full_valid, clock, reset, ostat.full, rsp_tvalid, "full buffer not valid")
   `EULR_ASSERT_NEXT(a_stall_hold, clock, reset, !en, $stable(vld_ff), "valid bits moved in stall")
   `EULR_ASSERT_NEXT(a_enter, clock, reset, req_tvalid && req_tready, vld_ff[0], "transfer lost")
   `EULR_ASSERT_NEXT(a_tail_hold, clock, reset, vld_ff[eulr_pkg::PIPE_LAT-1] && !en, vld_ff[eulr_pkg::PIPE_LAT-1], "result dropped in stall")
endmodule
